// File: sv/xcs_pkg.sv
package xcs_pkg;

  // Request fields on the input channel
  typedef struct packed {
    logic [1:0] func;
    logic [7:0] data;
    logic       image_end;
  } xcs_in_t;

  // Result fields on the output channel
  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       frame_end;
    logic [2:0] status;
  } xcs_out_t;

  // Sender phases
  typedef enum logic [2:0] {
    PH_WAKE      = 3'd0,
    PH_WAKE_WAIT = 3'd1,
    PH_FILL      = 3'd2,
    PH_SEND      = 3'd3,
    PH_WAIT      = 3'd4,
    PH_EOT       = 3'd5,
    PH_EOT_WAIT  = 3'd6,
    PH_DONE      = 3'd7
  } xcs_phase_t;

  // Request function codes
  localparam logic [1:0] FUNC_IMAGE = 2'd0;
  localparam logic [1:0] FUNC_REPLY = 2'd1;
  localparam logic [1:0] FUNC_TXRDY = 2'd2;
  // No meaning to the block: changes no state, and its result carries status none
  localparam logic [1:0] FUNC_NONE  = 2'd3;

  // Status codes
  localparam logic [2:0] ST_NONE     = 3'd0;
  localparam logic [2:0] ST_TAKEN    = 3'd1;
  localparam logic [2:0] ST_BUSY     = 3'd2;
  localparam logic [2:0] ST_ACKED    = 3'd3;
  localparam logic [2:0] ST_RESEND   = 3'd4;
  localparam logic [2:0] ST_UNEXPECT = 3'd5;
  localparam logic [2:0] ST_HS_DONE  = 3'd6;
  localparam logic [2:0] ST_FINISHED = 3'd7;

  // Line control bytes
  localparam logic [7:0] SOH_BYTE = 8'h01;
  localparam logic [7:0] EOT_BYTE = 8'h04;
  localparam logic [7:0] ACK_BYTE = 8'h06;
  localparam logic [7:0] NAK_BYTE = 8'h15;

  // Configuration register indexes
  localparam logic CFG_PAD_BYTE  = 1'b0;
  localparam logic CFG_SEND_WAKE = 1'b1;

  localparam logic [7:0] PAD_RESET = 8'h1a;

  // Boot-request wake pattern
  function automatic logic [7:0] wake_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0: b = 8'hbb;
      3'd1: b = 8'h11;
      3'd2: b = 8'h22;
      3'd3: b = 8'h33;
      3'd4: b = 8'h44;
      3'd5: b = 8'h55;
      3'd6: b = 8'h66;
      3'd7: b = 8'h77;
      default: b = 8'hbb;
    endcase
    return b;
  endfunction

endpackage

// File: sv/xcs_ram.sv
module xcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, read one entry with registered data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/xcs_out_skid.sv
module xcs_out_skid
  import xcs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  xcs_out_t push_data,
  output logic     space,
  output logic     out_valid,
  input  logic     out_ready,
  output xcs_out_t out_data
);

  logic     main_valid_r, main_valid_nxt;
  logic     skid_valid_r, skid_valid_nxt;
  xcs_out_t main_r, main_nxt;
  xcs_out_t skid_r, skid_nxt;
  logic     pop;

  assign pop       = main_valid_r && out_ready;
  assign space     = !skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_r;

  // Refill the output register from the skid entry first, then from new results
  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (pop || !main_valid_r) begin
      if (skid_valid_r) begin
        main_nxt       = skid_r;
        main_valid_nxt = 1'b1;
        if (push) begin
          skid_nxt = push_data;
        end else begin
          skid_valid_nxt = 1'b0;
        end
      end else begin
        main_valid_nxt = push;
        main_nxt       = push_data;
      end
    end else if (push) begin
      skid_nxt       = push_data;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

endmodule

// File: sv/xmodem_checksum_sender.sv
// XMODEM checksum sender with optional boot-request wake pattern. Every request
// (image byte, receiver reply or transmitter-ready) yields one result, so
// requests can arrive on every clock while in_ready is high; each result is
// registered in the output stage until the consumer takes it. A two-entry output
// stage keeps requests flowing while one result waits, and in_ready drops only
// when both entries are full. The block is buffered in a single RAM with one
// write and one registered read port; the read address follows the next send
// position so the data byte is already waiting when its transmitter-ready
// request arrives. The block store needs no clearing after reset.
module xmodem_checksum_sender
  import xcs_pkg::*;
#(
  parameter int BLOCK_BYTES = 128
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  xcs_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output xcs_out_t out_data,
  input  logic     cfg_we,
  input  logic     cfg_index,
  input  logic [7:0] cfg_data
);

  localparam int AW = $clog2(BLOCK_BYTES);
  localparam int CW = $clog2(BLOCK_BYTES + 1);
  localparam int SW = $clog2(BLOCK_BYTES + 4);
  localparam logic [CW-1:0] FILL_FULL = CW'(BLOCK_BYTES);
  localparam logic [SW-1:0] IDX_SUM   = SW'(BLOCK_BYTES + 3);
  localparam logic [SW-1:0] IDX_DATA  = SW'(3);
  localparam logic [SW-1:0] IDX_AFTER = SW'(BLOCK_BYTES + 4);

  xcs_phase_t    phase_r, phase_nxt;
  logic [CW-1:0] fill_count_r, fill_count_nxt;
  logic [SW-1:0] send_index_r, send_index_nxt;
  logic [7:0]    block_number_r, block_number_nxt;
  logic [7:0]    running_sum_r, running_sum_nxt;
  logic          image_done_r, image_done_nxt;
  logic [2:0]    pattern_index_r, pattern_index_nxt;
  logic          untouched_r, untouched_nxt;
  logic [7:0]    pad_byte_r, pad_byte_nxt;
  logic          send_wake_r, send_wake_nxt;

  logic          in_fire;
  xcs_out_t      result;
  logic          ram_we;
  logic [7:0]    ram_rdata;
  logic [SW-1:0] rd_idx;
  logic [SW-1:0] data_pos;

  assign in_fire  = in_valid && in_ready;
  assign ram_we   = in_fire && (in_data.func == FUNC_IMAGE) && (phase_r == PH_FILL)
                    && (fill_count_r < FILL_FULL);
  assign data_pos = send_index_r - IDX_DATA;
  // Read ahead at the position the next send step will use; writes happen only
  // while filling, so a read never meets a write to the same entry in use
  assign rd_idx   = send_index_nxt - IDX_DATA;

  xcs_ram #(
    .WIDTH(8),
    .DEPTH(BLOCK_BYTES)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(fill_count_r[AW-1:0]),
    .wdata(in_data.data),
    .raddr(rd_idx[AW-1:0]),
    .rdata(ram_rdata)
  );

  // Next state and result for the accepted request
  always_comb begin
    phase_nxt         = phase_r;
    fill_count_nxt    = fill_count_r;
    send_index_nxt    = send_index_r;
    block_number_nxt  = block_number_r;
    running_sum_nxt   = running_sum_r;
    image_done_nxt    = image_done_r;
    pattern_index_nxt = pattern_index_r;
    untouched_nxt     = untouched_r;
    pad_byte_nxt      = pad_byte_r;
    send_wake_nxt     = send_wake_r;
    result            = '0;

    if (in_fire) begin
      if (in_data.func != FUNC_NONE) begin
        untouched_nxt = 1'b0;
      end
      case (in_data.func)
        FUNC_IMAGE: begin
          if (ram_we) begin
            fill_count_nxt = fill_count_r + CW'(1);
            result.status  = ST_TAKEN;
            if (in_data.image_end) begin
              image_done_nxt = 1'b1;
            end
            if (in_data.image_end || (fill_count_nxt >= FILL_FULL)) begin
              phase_nxt       = PH_SEND;
              send_index_nxt  = '0;
              running_sum_nxt = '0;
            end
          end else begin
            result.status = ST_BUSY;
          end
        end
        FUNC_REPLY: begin
          if (phase_r == PH_WAKE_WAIT) begin
            if (in_data.data == NAK_BYTE) begin
              phase_nxt     = PH_FILL;
              result.status = ST_HS_DONE;
            end else begin
              phase_nxt         = PH_WAKE;
              pattern_index_nxt = '0;
              result.status     = ST_UNEXPECT;
            end
          end else if (phase_r == PH_WAIT) begin
            if (in_data.data == NAK_BYTE) begin
              phase_nxt       = PH_SEND;
              send_index_nxt  = '0;
              running_sum_nxt = '0;
              result.status   = ST_RESEND;
            end else begin
              result.status    = (in_data.data == ACK_BYTE) ? ST_ACKED : ST_UNEXPECT;
              // Advance to the next block
              block_number_nxt = block_number_r + 8'd1;
              fill_count_nxt   = '0;
              send_index_nxt   = '0;
              running_sum_nxt  = '0;
              phase_nxt        = image_done_r ? PH_EOT : PH_FILL;
            end
          end else if (phase_r == PH_EOT_WAIT) begin
            phase_nxt     = PH_DONE;
            result.status = ST_FINISHED;
          end
        end
        FUNC_TXRDY: begin
          if (phase_r == PH_WAKE) begin
            result.tx_valid = 1'b1;
            result.tx_byte  = wake_byte(pattern_index_r);
            if (pattern_index_r == 3'd7) begin
              result.frame_end  = 1'b1;
              pattern_index_nxt = '0;
              phase_nxt         = PH_WAKE_WAIT;
            end else begin
              pattern_index_nxt = pattern_index_r + 3'd1;
            end
          end else if (phase_r == PH_SEND) begin
            result.tx_valid = 1'b1;
            if (send_index_r == SW'(0)) begin
              result.tx_byte  = SOH_BYTE;
              running_sum_nxt = '0;
            end else if (send_index_r == SW'(1)) begin
              result.tx_byte = block_number_r;
            end else if (send_index_r == SW'(2)) begin
              result.tx_byte = ~block_number_r;
            end else if (send_index_r < IDX_SUM) begin
              // Data position: stored byte or pad past the fill point
              result.tx_byte  = (data_pos < SW'(fill_count_r)) ? ram_rdata : pad_byte_r;
              running_sum_nxt = running_sum_r + result.tx_byte;
            end else begin
              result.tx_byte   = running_sum_r;
              result.frame_end = 1'b1;
              phase_nxt        = PH_WAIT;
            end
            send_index_nxt = send_index_r + SW'(1);
          end else if (phase_r == PH_EOT) begin
            result.tx_valid  = 1'b1;
            result.tx_byte   = EOT_BYTE;
            result.frame_end = 1'b1;
            phase_nxt        = PH_EOT_WAIT;
          end
        end
        default: begin
          result.status = ST_NONE;
        end
      endcase
    end

    // Configuration writes
    if (cfg_we) begin
      case (cfg_index)
        CFG_PAD_BYTE: begin
          pad_byte_nxt = cfg_data;
        end
        CFG_SEND_WAKE: begin
          send_wake_nxt = cfg_data[0];
          if (untouched_r) begin
            phase_nxt = cfg_data[0] ? PH_WAKE : PH_FILL;
          end
        end
        default: begin
          pad_byte_nxt = pad_byte_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_WAKE;
      fill_count_r    <= '0;
      send_index_r    <= '0;
      block_number_r  <= 8'd1;
      running_sum_r   <= '0;
      image_done_r    <= 1'b0;
      pattern_index_r <= '0;
      untouched_r     <= 1'b1;
      pad_byte_r      <= PAD_RESET;
      send_wake_r     <= 1'b1;
    end else begin
      phase_r         <= phase_nxt;
      fill_count_r    <= fill_count_nxt;
      send_index_r    <= send_index_nxt;
      block_number_r  <= block_number_nxt;
      running_sum_r   <= running_sum_nxt;
      image_done_r    <= image_done_nxt;
      pattern_index_r <= pattern_index_nxt;
      untouched_r     <= untouched_nxt;
      pad_byte_r      <= pad_byte_nxt;
      send_wake_r     <= send_wake_nxt;
    end
  end

  // Hold results until the consumer takes them
  xcs_out_skid u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_fire),
    .push_data(result),
    .space    (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

`ifndef SYNTH
  a_write_only_filling: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (phase_r == PH_FILL))
    else $error("block store written outside fill phase");

  a_sum_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_data.func == FUNC_TXRDY) && (phase_r == PH_SEND)
     && (send_index_r == IDX_SUM)) |=> (phase_r == PH_WAIT))
    else $error("checksum byte did not end the frame");

  // The send position rests one past the checksum while the reply is awaited
  a_send_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (send_index_r <= IDX_AFTER) && (fill_count_r <= FILL_FULL))
    else $error("send or fill position out of range");

  a_result_follows_request: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !out_valid) |=> out_valid)
    else $error("accepted request produced no result");
`endif

endmodule
